[rtl/core/extent_run_list_decoder_defines.svh]
// assertion macros shared by the run list decoder modules
`ifndef EXTENT_RUN_LIST_DECODER_DEFINES_SVH
`define EXTENT_RUN_LIST_DECODER_DEFINES_SVH

// condition implies consequence in the same cycle
`define ERLD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("erld same-cycle check failed");

// condition implies consequence in the next cycle
`define ERLD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("erld next-cycle check failed");

`endif

[rtl/core/erld_pkg.sv]
// package: types, codes and constants of the extent run list decoder
package erld_pkg;

   localparam int unsigned CLUSTER_BYTES_W = 22;
   localparam int unsigned PART_OFFSET_W   = 48;
   localparam int unsigned CSR_DATA_W      = 48;
   localparam int unsigned CSR_INDEX_W     = 1;

   localparam logic [CLUSTER_BYTES_W-1:0] CLUSTER_BYTES_RESET = 22'd4096;
   localparam logic [PART_OFFSET_W-1:0]   PART_OFFSET_RESET   = '0;

   localparam logic [CSR_INDEX_W-1:0] CSR_CLUSTER_BYTES    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARTITION_OFFSET = 1'b1;

   localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;

   localparam int unsigned MID_DEPTH_DEFAULT = 2;
   localparam int unsigned OUT_DEPTH_DEFAULT = 4;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LENGTH,
      PH_OFFSET,
      PH_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_LIST_END,
      ST_TRUNCATED,
      ST_BAD_NIBBLE
   } status_type;

   typedef struct packed {
      status_type  status;
      logic        run_valid;
      logic        list_done;
      logic [63:0] run_clusters;
      logic [63:0] start_cluster;
   } run_task_type;

   typedef struct packed {
      status_type  status;
      logic        run_valid;
      logic [63:0] run_clusters;
      logic [63:0] start_cluster;
      logic [63:0] byte_address;
      logic [31:0] byte_count;
      logic        list_done;
   } run_result_type;

endpackage

[rtl/core/extent_run_list_decoder.sv]
// extent run list decoder: top level with config registers, task queue and result queue
// one run list byte accepted per cycle, sustained, while the task queue has room
// a result moves through task queue, back stage register and result queue to the rsp ports
// the back stage registers the 32x22 partial products and forms the sum from those registers
// reset is synchronous: decoder at header phase, queues empty, cluster size 4096, offset 0
module extent_run_list_decoder import erld_pkg::*; #(
   parameter int unsigned MID_DEPTH = MID_DEPTH_DEFAULT,
   parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [7:0]               req_run_byte,
   input  logic                     req_list_end,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [1:0]               rsp_status,
   output logic                     rsp_run_valid,
   output logic [63:0]              rsp_run_clusters,
   output logic signed [63:0]       rsp_start_cluster,
   output logic [63:0]              rsp_byte_address,
   output logic [31:0]              rsp_byte_count,
   output logic                     rsp_list_done,
   input  logic                     csr_wen,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   localparam int unsigned MID_LVL_W = $clog2(MID_DEPTH + 1);

   logic [CLUSTER_BYTES_W-1:0] cluster_bytes_ff, cluster_bytes_in;
   logic [PART_OFFSET_W-1:0]   part_offset_ff, part_offset_in;

   logic                 req_accept;
   logic                 emit;
   run_task_type         emit_task;
   logic [MID_LVL_W-1:0] mid_level;
   logic                 mid_empty, mid_pop;
   run_task_type         mid_item;
   run_result_type       rsp_item;

   always_comb begin
      cluster_bytes_in = cluster_bytes_ff;
      part_offset_in   = part_offset_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_CLUSTER_BYTES: begin
               cluster_bytes_in = csr_data[CLUSTER_BYTES_W-1:0];
            end
            CSR_PARTITION_OFFSET: begin
               part_offset_in = csr_data[PART_OFFSET_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_bytes_ff <= CLUSTER_BYTES_RESET;
         part_offset_ff   <= PART_OFFSET_RESET;
      end else begin
         cluster_bytes_ff <= cluster_bytes_in;
         part_offset_ff   <= part_offset_in;
      end
   end

   assign req_full   = (mid_level == MID_LVL_W'(MID_DEPTH));
   assign req_accept = req_push && !req_full;
   assign mid_empty  = (mid_level == '0);

   erld_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .run_byte  (req_run_byte),
      .list_end  (req_list_end),
      .emit      (emit),
      .emit_task (emit_task)
   );

   erld_queue #(
      .DEPTH     (MID_DEPTH),
      .item_type (run_task_type)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_item (emit_task),
      .pop       (mid_pop),
      .pop_item  (mid_item),
      .level     (mid_level)
   );

   erld_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cluster_bytes         (cluster_bytes_ff),
      .partition_byte_offset (part_offset_ff),
      .mid_empty             (mid_empty),
      .mid_item              (mid_item),
      .mid_pop               (mid_pop),
      .rsp_pop               (rsp_pop),
      .rsp_empty             (rsp_empty),
      .rsp_item              (rsp_item)
   );

   assign rsp_status        = rsp_item.status;
   assign rsp_run_valid     = rsp_item.run_valid;
   assign rsp_run_clusters  = rsp_item.run_clusters;
   assign rsp_start_cluster = rsp_item.start_cluster;
   assign rsp_byte_address  = rsp_item.byte_address;
   assign rsp_byte_count    = rsp_item.byte_count;
   assign rsp_list_done     = rsp_item.list_done;

endmodule

[rtl/core/erld_queue.sv]
// small register queue used between the stages of the decoder
`include "extent_run_list_decoder_defines.svh"

module erld_queue import erld_pkg::*; #(
   parameter int unsigned DEPTH = MID_DEPTH_DEFAULT,
   parameter type item_type = run_task_type
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  item_type                       push_item,
   input  logic                           pop,
   output item_type                       pop_item,
   output logic [$clog2(DEPTH+1)-1:0]     level
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned LVL_W = $clog2(DEPTH + 1);

   item_type          store_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0]  level_ff, level_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      level_in = level_ff + LVL_W'(push) - LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item = store_ff[rd_ptr_ff];
   assign level    = level_ff;

   `ERLD_ASSERT_NOW(a_no_push_when_full, clock, reset, level_ff == LVL_W'(DEPTH), !push)

endmodule

[rtl/core/erld_front.sv]
// front end: walks the run list bytes and emits one task per finished run or list event
`include "extent_run_list_decoder_defines.svh"

module erld_front import erld_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   run_byte,
   input  logic         list_end,
   output logic         emit,
   output run_task_type emit_task
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  len_left_ff, len_left_in;
   logic [3:0]  off_left_ff, off_left_in;
   logic [3:0]  off_width_ff, off_width_in;
   logic [2:0]  pos_ff, pos_in;
   logic [63:0] len_acc_ff, len_acc_in;
   logic [63:0] off_acc_ff, off_acc_in;
   logic [63:0] cur_ff, cur_in;

   logic [3:0]  hdr_lo, hdr_hi;
   logic        hdr_zero, hdr_bad;
   logic [3:0]  len_left_dec, off_left_dec;
   logic        len_done, off_done;
   logic [63:0] byte_shifted, len_acc_nxt, off_acc_nxt;
   logic [63:0] fin_len, fin_off, off_ext, ext_mask, cur_nxt;
   logic [5:0]  sign_idx;
   logic        run_finish;

   assign hdr_lo   = run_byte[3:0];
   assign hdr_hi   = run_byte[7:4];
   assign hdr_zero = (run_byte == 8'd0);
   assign hdr_bad  = (hdr_lo > MAX_FIELD_BYTES) || (hdr_hi > MAX_FIELD_BYTES);

   assign len_left_dec = len_left_ff - 4'd1;
   assign off_left_dec = off_left_ff - 4'd1;
   assign len_done     = (len_left_dec == 4'd0);
   assign off_done     = (off_left_dec == 4'd0);

   assign byte_shifted = 64'(run_byte) << {pos_ff, 3'b000};
   assign len_acc_nxt  = len_acc_ff | byte_shifted;
   assign off_acc_nxt  = off_acc_ff | byte_shifted;

   assign fin_len = (phase_ff == PH_LENGTH) ? len_acc_nxt : len_acc_ff;
   assign fin_off = (phase_ff == PH_OFFSET) ? off_acc_nxt : off_acc_ff;

   // sign extension from the offset field width
   assign sign_idx = {off_width_ff[2:0], 3'b000} - 6'd1;
   assign ext_mask = ~64'd0 << {off_width_ff[2:0], 3'b000};
   assign off_ext  = (off_width_ff != 4'd0 && off_width_ff < MAX_FIELD_BYTES
                      && fin_off[sign_idx]) ? (fin_off | ext_mask) : fin_off;
   assign cur_nxt  = cur_ff + off_ext;

   assign run_finish = ((phase_ff == PH_LENGTH) && len_done && (off_left_ff == 4'd0))
                    || ((phase_ff == PH_OFFSET) && off_done);

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (list_end) begin
            phase_in = PH_HEADER;
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  if (hdr_zero || hdr_bad) begin
                     phase_in = PH_SKIP;
                  end else if (hdr_lo != 4'd0) begin
                     phase_in = PH_LENGTH;
                  end else begin
                     phase_in = PH_OFFSET;
                  end
               end
               PH_LENGTH: begin
                  if (len_done) begin
                     phase_in = (off_left_ff == 4'd0) ? PH_HEADER : PH_OFFSET;
                  end
               end
               PH_OFFSET: begin
                  if (off_done) begin
                     phase_in = PH_HEADER;
                  end
               end
               PH_SKIP: begin
                  phase_in = PH_SKIP;
               end
            endcase
         end
      end
   end

   always_comb begin
      emit      = 1'b0;
      emit_task = '0;
      if (accept) begin
         unique case (phase_ff) inside
            PH_HEADER: begin
               emit                = hdr_zero || hdr_bad || list_end;
               emit_task.list_done = 1'b1;
               if (hdr_zero) begin
                  emit_task.status = ST_LIST_END;
               end else if (hdr_bad) begin
                  emit_task.status = ST_BAD_NIBBLE;
               end else begin
                  emit_task.status = ST_TRUNCATED;
               end
            end
            PH_LENGTH, PH_OFFSET: begin
               if (run_finish) begin
                  emit                    = 1'b1;
                  emit_task.status        = ST_RUN;
                  emit_task.run_valid     = 1'b1;
                  emit_task.list_done     = list_end;
                  emit_task.run_clusters  = fin_len;
                  emit_task.start_cluster = cur_nxt;
               end else if (list_end) begin
                  emit                = 1'b1;
                  emit_task.status    = ST_TRUNCATED;
                  emit_task.list_done = 1'b1;
               end
            end
            PH_SKIP: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      len_left_in  = len_left_ff;
      off_left_in  = off_left_ff;
      off_width_in = off_width_ff;
      pos_in       = pos_ff;
      len_acc_in   = len_acc_ff;
      off_acc_in   = off_acc_ff;
      cur_in       = cur_ff;
      if (accept) begin
         if (list_end) begin
            len_left_in  = '0;
            off_left_in  = '0;
            off_width_in = '0;
            pos_in       = '0;
            len_acc_in   = '0;
            off_acc_in   = '0;
            cur_in       = '0;
         end else if (run_finish) begin
            len_left_in  = '0;
            off_left_in  = '0;
            off_width_in = '0;
            pos_in       = '0;
            len_acc_in   = '0;
            off_acc_in   = '0;
            cur_in       = cur_nxt;
         end else begin
            case (phase_ff)
               PH_HEADER: begin
                  if (!hdr_zero && !hdr_bad) begin
                     len_left_in  = hdr_lo;
                     off_left_in  = hdr_hi;
                     off_width_in = hdr_hi;
                     pos_in       = '0;
                     len_acc_in   = '0;
                     off_acc_in   = '0;
                  end
               end
               PH_LENGTH: begin
                  len_acc_in  = len_acc_nxt;
                  len_left_in = len_left_dec;
                  pos_in      = len_done ? 3'd0 : pos_ff + 3'd1;
               end
               PH_OFFSET: begin
                  off_acc_in  = off_acc_nxt;
                  off_left_in = off_left_dec;
                  pos_in      = pos_ff + 3'd1;
               end
               default: begin
                  pos_in = pos_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         len_left_ff  <= '0;
         off_left_ff  <= '0;
         off_width_ff <= '0;
         pos_ff       <= '0;
         len_acc_ff   <= '0;
         off_acc_ff   <= '0;
         cur_ff       <= '0;
      end else begin
         phase_ff     <= phase_in;
         len_left_ff  <= len_left_in;
         off_left_ff  <= off_left_in;
         off_width_ff <= off_width_in;
         pos_ff       <= pos_in;
         len_acc_ff   <= len_acc_in;
         off_acc_ff   <= off_acc_in;
         cur_ff       <= cur_in;
      end
   end

   `ERLD_ASSERT_NEXT(a_list_end_restarts, clock, reset, accept && list_end, (phase_ff == PH_HEADER) && (cur_ff == 64'd0))

endmodule

[rtl/core/erld_back.sv]
// back end: address and byte count arithmetic, result queue
`include "extent_run_list_decoder_defines.svh"

module erld_back import erld_pkg::*; #(
   parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [CLUSTER_BYTES_W-1:0] cluster_bytes,
   input  logic [PART_OFFSET_W-1:0]   partition_byte_offset,
   input  logic                       mid_empty,
   input  run_task_type               mid_item,
   output logic                       mid_pop,
   input  logic                       rsp_pop,
   output logic                       rsp_empty,
   output run_result_type             rsp_item
);

   localparam int unsigned OUT_LVL_W = $clog2(OUT_DEPTH + 1);
   localparam int unsigned PROD_LO_W = 32 + CLUSTER_BYTES_W;

   logic                  s1_valid_ff, s1_valid_in;
   run_task_type          s1_task_ff;
   logic [PROD_LO_W-1:0]  prod_lo_ff, prod_lo_in;
   logic [31:0]           prod_hi_ff, prod_hi_in;
   logic [31:0]           count_ff, count_in;

   logic [OUT_LVL_W-1:0]  out_level;
   logic                  out_space, out_pop;
   run_result_type        result;

   assign out_space = ({1'b0, out_level} + (OUT_LVL_W + 1)'(s1_valid_ff))
                      < (OUT_LVL_W + 1)'(OUT_DEPTH);
   assign mid_pop     = !mid_empty && out_space;
   assign s1_valid_in = mid_pop;

   // partial products of the start cluster, only low 32 bits of the upper half matter
   assign prod_lo_in = PROD_LO_W'(mid_item.start_cluster[31:0]) * PROD_LO_W'(cluster_bytes);
   assign prod_hi_in = mid_item.start_cluster[63:32] * 32'(cluster_bytes);
   assign count_in   = mid_item.run_clusters[31:0] * 32'(cluster_bytes);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         s1_task_ff <= mid_item;
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
         count_ff   <= count_in;
      end
   end

   always_comb begin
      result               = '0;
      result.status        = s1_task_ff.status;
      result.run_valid     = s1_task_ff.run_valid;
      result.list_done     = s1_task_ff.list_done;
      result.run_clusters  = s1_task_ff.run_clusters;
      result.start_cluster = s1_task_ff.start_cluster;
      if (s1_task_ff.run_valid) begin
         result.byte_address = 64'(partition_byte_offset) + 64'(prod_lo_ff)
                               + {prod_hi_ff, 32'd0};
         result.byte_count   = count_ff;
      end
   end

   assign rsp_empty = (out_level == '0);
   assign out_pop   = rsp_pop && !rsp_empty;

   erld_queue #(
      .DEPTH     (OUT_DEPTH),
      .item_type (run_result_type)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_item (result),
      .pop       (out_pop),
      .pop_item  (rsp_item),
      .level     (out_level)
   );

   `ERLD_ASSERT_NOW(a_stage_has_room, clock, reset, s1_valid_ff, out_level < OUT_LVL_W'(OUT_DEPTH))

endmodule

[verif/extent_run_list_decoder_test.sv]
// testbench for the extent run list decoder: directed table, then random run lists
module extent_run_list_decoder_test import erld_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 160;
   localparam int DIRECTED_ROWS = 23;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 10;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SEND,
      IDLE_RECV,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [7:0]     run_byte;
      logic           list_end;
      logic           typed;
      run_result_type res;
   } stim_type;

   localparam run_result_type NO_RES = '0;
   localparam run_result_type LIST_END_RES =
      '{ST_LIST_END, 1'b0, 64'd0, 64'd0, 64'd0, 32'd0, 1'b1};
   localparam run_result_type TRUNC_RES =
      '{ST_TRUNCATED, 1'b0, 64'd0, 64'd0, 64'd0, 32'd0, 1'b1};
   localparam run_result_type BAD_NIBBLE_RES =
      '{ST_BAD_NIBBLE, 1'b0, 64'd0, 64'd0, 64'd0, 32'd0, 1'b1};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [7:0]             req_run_byte = 8'd0;
   logic                   req_list_end = 1'b0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [1:0]             rsp_status;
   logic                   rsp_run_valid;
   logic [63:0]            rsp_run_clusters;
   logic signed [63:0]     rsp_start_cluster;
   logic [63:0]            rsp_byte_address;
   logic [31:0]            rsp_byte_count;
   logic                   rsp_list_done;
   logic                   csr_wen = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_CLUSTER_BYTES;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // decoder state as predicted
   phase_type              dec_phase = PH_HEADER;
   logic [3:0]             len_left = '0;
   logic [3:0]             off_left = '0;
   logic [3:0]             off_width = '0;
   logic [2:0]             byte_pos = '0;
   logic [63:0]            len_acc = '0;
   logic [63:0]            off_acc = '0;
   logic [63:0]            cur_cluster = '0;
   logic [21:0]            cfg_cluster_bytes = CLUSTER_BYTES_RESET;
   logic [47:0]            cfg_part_offset = PART_OFFSET_RESET;

   run_result_type         due_results [$];
   stim_type               list_bytes [$];
   stim_type               directed [DIRECTED_ROWS];
   idle_mode_type          phase_mode [PHASES];
   logic [21:0]            phase_cb [PHASES];
   logic [47:0]            phase_po [PHASES];
   int                     send_pct = 0;
   int                     recv_pct = 0;
   int                     live_items = 0;
   int                     lists_sent = 0;
   int                     errors = 0;
   int                     idle_cycles = 0;

   extent_run_list_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_run_byte      (req_run_byte),
      .req_list_end      (req_list_end),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_status        (rsp_status),
      .rsp_run_valid     (rsp_run_valid),
      .rsp_run_clusters  (rsp_run_clusters),
      .rsp_start_cluster (rsp_start_cluster),
      .rsp_byte_address  (rsp_byte_address),
      .rsp_byte_count    (rsp_byte_count),
      .rsp_list_done     (rsp_list_done),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #10 clock = ~clock;

   function automatic void clear_run();
      len_left = '0;
      off_left = '0;
      off_width = '0;
      byte_pos = '0;
      len_acc = '0;
      off_acc = '0;
   endfunction

   function automatic void end_list();
      clear_run();
      cur_cluster = '0;
      dec_phase = PH_HEADER;
   endfunction

   function automatic run_result_type make_result(status_type st, logic valid, logic done);
      run_result_type r;
      r = '0;
      r.status = st;
      r.run_valid = valid;
      r.list_done = done;
      if (valid) begin
         r.run_clusters = len_acc;
         r.start_cluster = cur_cluster;
         r.byte_address = {16'd0, cfg_part_offset} + cur_cluster * 64'(cfg_cluster_bytes);
         r.byte_count = 32'(len_acc * 64'(cfg_cluster_bytes));
      end
      return r;
   endfunction

   function automatic void finish_run(logic last, output run_result_type r);
      logic [63:0] off;
      off = off_acc;
      // sign extend offsets narrower than 8 bytes
      if (off_width > 0 && off_width < 8) begin
         if (off[8 * off_width - 1]) off = off | (~64'd0 << (8 * off_width));
      end
      cur_cluster = cur_cluster + off;
      r = make_result(ST_RUN, 1'b1, last);
      if (last) begin
         end_list();
      end else begin
         clear_run();
         dec_phase = PH_HEADER;
      end
   endfunction

   function automatic bit decode_byte(logic [7:0] b, logic last, output run_result_type r);
      r = NO_RES;
      case (dec_phase)
         PH_HEADER: begin
            if (b == 8'h00 || b[3:0] > MAX_FIELD_BYTES || b[7:4] > MAX_FIELD_BYTES) begin
               r = make_result((b == 8'h00) ? ST_LIST_END : ST_BAD_NIBBLE, 1'b0, 1'b1);
               if (last) end_list();
               else dec_phase = PH_SKIP;
               return 1'b1;
            end
            if (last) begin
               r = make_result(ST_TRUNCATED, 1'b0, 1'b1);
               end_list();
               return 1'b1;
            end
            clear_run();
            len_left = b[3:0];
            off_left = b[7:4];
            off_width = b[7:4];
            dec_phase = (b[3:0] != 0) ? PH_LENGTH : PH_OFFSET;
            return 1'b0;
         end
         PH_LENGTH: begin
            len_acc = len_acc | (64'(b) << (8 * byte_pos));
            byte_pos = byte_pos + 3'd1;
            len_left = len_left - 4'd1;
            if (len_left == 0) begin
               byte_pos = '0;
               if (off_left == 0) begin
                  finish_run(last, r);
                  return 1'b1;
               end
               dec_phase = PH_OFFSET;
            end
         end
         PH_OFFSET: begin
            off_acc = off_acc | (64'(b) << (8 * byte_pos));
            byte_pos = byte_pos + 3'd1;
            off_left = off_left - 4'd1;
            if (off_left == 0) begin
               finish_run(last, r);
               return 1'b1;
            end
         end
         default: begin
            if (last) end_list();
            return 1'b0;
         end
      endcase
      if (last) begin
         r = make_result(ST_TRUNCATED, 1'b0, 1'b1);
         end_list();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic add_byte(logic [7:0] b, logic last);
      stim_type s;
      s = '0;
      s.run_byte = b;
      s.list_end = last;
      list_bytes.push_back(s);
   endtask

   // mostly well-formed lists, some cut short, some pure noise
   task automatic build_list();
      int kind;
      int nruns;
      int lo;
      int hi;
      int tail;
      int ending;
      int cut;
      list_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind >= 88) begin
         tail = $urandom_range(1, 12);
         repeat (tail) add_byte(8'($urandom), $urandom_range(0, 5) == 0);
         add_byte(8'($urandom), 1'b1);
         return;
      end
      nruns = $urandom_range(1, 5);
      repeat (nruns) begin
         lo = $urandom_range(0, 8);
         hi = $urandom_range(0, 8);
         if (lo == 0 && hi == 0) lo = 1;
         add_byte({hi[3:0], lo[3:0]}, 1'b0);
         repeat (lo + hi) add_byte(8'($urandom), 1'b0);
      end
      ending = $urandom_range(0, 2);
      if (ending == 0) begin
         add_byte(8'h00, 1'b1);
      end else if (ending == 1) begin
         list_bytes[list_bytes.size() - 1].list_end = 1'b1;
      end else begin
         add_byte(8'h00, 1'b0);
         tail = $urandom_range(0, 3);
         repeat (tail) add_byte(8'($urandom), 1'b0);
         add_byte(8'($urandom), 1'b1);
      end
      if (kind >= 70) begin
         cut = $urandom_range(0, list_bytes.size() - 1);
         while (list_bytes.size() > cut + 1) void'(list_bytes.pop_back());
         list_bytes[cut].list_end = 1'b1;
      end
   endtask

   task automatic send_item(stim_type s);
      run_result_type r;
      bit has;
      while ($urandom_range(0, 99) < send_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_run_byte <= s.run_byte;
      req_list_end <= s.list_end;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (dec_phase != PH_SKIP) live_items++;
      has = decode_byte(s.run_byte, s.list_end, r);
      if (s.typed) due_results.push_back(s.res);
      else if (has) due_results.push_back(r);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      if (idx == CSR_CLUSTER_BYTES) cfg_cluster_bytes = value[21:0];
      else cfg_part_offset = value[47:0];
   endtask

   task automatic settle();
      while (due_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic check_result(run_result_type want);
      compare_field("status", 64'(want.status), 64'(rsp_status));
      compare_field("run_valid", 64'(want.run_valid), 64'(rsp_run_valid));
      compare_field("run_clusters", want.run_clusters, rsp_run_clusters);
      compare_field("start_cluster", want.start_cluster, rsp_start_cluster);
      compare_field("byte_address", want.byte_address, rsp_byte_address);
      compare_field("byte_count", 64'(want.byte_count), 64'(rsp_byte_count));
      compare_field("list_done", 64'(want.list_done), 64'(rsp_list_done));
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (due_results.size() == 0) begin
               $display("%0t: expected no item, actual status %h clusters %h", $time,
                        rsp_status, rsp_run_clusters);
               errors++;
            end else begin
               check_result(due_results.pop_front());
            end
         end
         rsp_pop <= ($urandom_range(0, 99) >= recv_pct);
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("extent_run_list_decoder test failed");
      $finish;
   end

   initial begin
      directed = '{
         '{8'h00, 1'b1, 1'b1, LIST_END_RES},
         '{8'h11, 1'b0, 1'b0, NO_RES},
         '{8'h05, 1'b0, 1'b0, NO_RES},
         '{8'h10, 1'b0, 1'b1, '{ST_RUN, 1'b1, 64'd5, 64'd16, 64'h10000, 32'h5000, 1'b0}},
         '{8'h09, 1'b0, 1'b1, BAD_NIBBLE_RES},
         '{8'h00, 1'b1, 1'b0, NO_RES},
         '{8'h21, 1'b0, 1'b0, NO_RES},
         '{8'h01, 1'b1, 1'b1, TRUNC_RES},
         '{8'h01, 1'b0, 1'b0, NO_RES},
         '{8'hFF, 1'b0, 1'b1, '{ST_RUN, 1'b1, 64'd255, 64'd0, 64'd0, 32'hFF000, 1'b0}},
         '{8'h18, 1'b0, 1'b0, NO_RES},
         '{8'hFF, 1'b0, 1'b0, NO_RES},
         '{8'hFF, 1'b0, 1'b0, NO_RES},
         '{8'hFF, 1'b0, 1'b0, NO_RES},
         '{8'hFF, 1'b0, 1'b0, NO_RES},
         '{8'hFF, 1'b0, 1'b0, NO_RES},
         '{8'hFF, 1'b0, 1'b0, NO_RES},
         '{8'hFF, 1'b0, 1'b0, NO_RES},
         '{8'hFF, 1'b0, 1'b0, NO_RES},
         '{8'hFF, 1'b1, 1'b0, NO_RES},
         '{8'h80, 1'b1, 1'b1, TRUNC_RES},
         '{8'hF0, 1'b0, 1'b1, BAD_NIBBLE_RES},
         '{8'h33, 1'b1, 1'b0, NO_RES}
      };
      phase_mode = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                     IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
      phase_cb = '{22'd1, 22'd2097152, 22'd0, 22'd512, 22'd0, 22'h3FFFFF, 22'd0, 22'd4096};
      phase_cb[2] = 22'($urandom_range(1, 2097152));
      phase_cb[6] = 22'($urandom_range(1, 2097152));
      phase_po = '{48'd0, 48'hFFFF_FFFF_FFFF, 48'd0, 48'd0,
                   48'd0, 48'hFFFF_FFFF_FFFF, 48'd0, 48'd0};
      phase_po[2] = 48'({$urandom, $urandom});
      phase_po[3] = 48'({$urandom, $urandom});
      phase_po[6] = 48'({$urandom, $urandom});
      phase_po[7] = 48'({$urandom, $urandom});

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_item(directed[i]);
      req_push <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         settle();
         csr_write(CSR_CLUSTER_BYTES, {26'($urandom), phase_cb[p]});
         csr_write(CSR_PARTITION_OFFSET, phase_po[p]);
         csr_wen <= 1'b0;
         send_pct = (phase_mode[p] == IDLE_SEND) ? 84 : (phase_mode[p] == IDLE_BOTH) ? 17 : 0;
         recv_pct = (phase_mode[p] == IDLE_RECV) ? 84 : (phase_mode[p] == IDLE_BOTH) ? 17 : 0;
         live_items = 0;
         while (live_items < ITEMS_PER_PHASE) begin
            build_list();
            // hold off until the result queue has drained
            if (lists_sent % 12 == 5) begin
               req_push <= 1'b0;
               @(posedge clock);
               while (due_results.size() != 0) @(posedge clock);
            end
            lists_sent++;
            foreach (list_bytes[i]) send_item(list_bytes[i]);
         end
         req_push <= 1'b0;
      end

      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("extent_run_list_decoder test passed");
      end else begin
         $display("extent_run_list_decoder test failed");
      end
      $finish;
   end

endmodule
